FILE: hdl/egsa_pkg.sv
package egsa_pkg;

   localparam int OFFSET_DEPTH_DEFAULT   = 4096;
   localparam int GLOBAL_DEPTH_DEFAULT   = 4096;
   localparam int MAX_NODES_DEFAULT      = 64;
   localparam int MAX_COMPONENTS_DEFAULT = 8;

   localparam int ELEMENT_LIMIT = 4096;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 13;

   typedef enum logic [1:0] {
      KIND_LOAD_OFFSET = 2'd0,
      KIND_WRITE_WORD  = 2'd1,
      KIND_READ_WORD   = 2'd2,
      KIND_SWEEP_STEP  = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SWEEP_MODE        = 3'd0,
      CSR_ELEMENT_COUNT     = 3'd1,
      CSR_NODES_PER_ELEMENT = 3'd2,
      CSR_COMPONENT_COUNT   = 3'd3,
      CSR_COMPONENT_STRIDE  = 3'd4,
      CSR_GLOBAL_SIZE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      kind_type           kind;
      logic [11:0]        address;
      logic [11:0]        node_offset;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [14:0]        element_position;
      logic [11:0]        global_address;
      logic               sweep_last;
      logic               fault;
   } rsp_payload_type;

endpackage

FILE: hdl/egsa_sweep.sv
module egsa_sweep import egsa_pkg::*; #(
   parameter int OFFSET_DEPTH   = OFFSET_DEPTH_DEFAULT,
   parameter int MAX_NODES      = MAX_NODES_DEFAULT,
   parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEFAULT,
   localparam int OAW = $clog2(OFFSET_DEPTH),
   localparam int CCW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
   localparam int KSW = CCW + 12
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [12:0]    elems,
   input  logic [6:0]     nodes,
   input  logic [3:0]     comps,
   input  logic [11:0]    stride,
   output logic [OAW-1:0] table_index,
   output logic [KSW-1:0] stride_offset_ff,
   output logic [14:0]    pos_part_ff,
   output logic [11:0]    elem_pos_ff,
   output logic           last_ff
);

   localparam int NCW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCMP = (NCW + 1 > 7) ? NCW + 1 : 7;
   localparam int CCMP = (CCW + 1 > 4) ? CCW + 1 : 4;
   localparam int TW   = 20;

   logic [11:0]    elem_ff, elem_in;
   logic [CCW-1:0] comp_ff, comp_in;
   logic [NCW-1:0] node_ff, node_in;
   logic           node_wrap, comp_wrap, elem_wrap, last_in;
   logic [TW-1:0]  index_full;

   assign index_full  = TW'(elem_ff) * TW'(nodes) + TW'(node_ff);
   assign table_index = index_full[OAW-1:0];

   always_comb begin
      node_wrap = (NCMP'(node_ff) + NCMP'(1)) >= NCMP'(nodes);
      comp_wrap = (CCMP'(comp_ff) + CCMP'(1)) >= CCMP'(comps);
      elem_wrap = (13'(elem_ff) + 13'd1) >= elems;
      node_in   = node_wrap ? '0 : node_ff + NCW'(1);
      comp_in   = comp_ff;
      elem_in   = elem_ff;
      last_in   = 1'b0;
      if (node_wrap) begin
         comp_in = comp_wrap ? '0 : comp_ff + CCW'(1);
         if (comp_wrap) begin
            elem_in = elem_wrap ? '0 : elem_ff + 12'd1;
            last_in = elem_wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff <= '0;
         comp_ff <= '0;
         node_ff <= '0;
      end else if (step) begin
         elem_ff <= elem_in;
         comp_ff <= comp_in;
         node_ff <= node_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         stride_offset_ff <= KSW'(comp_ff) * KSW'(stride);
         pos_part_ff      <= 15'(comp_ff) * 15'(nodes) + 15'(node_ff);
         elem_pos_ff      <= elem_ff;
         last_ff          <= last_in;
      end
   end

endmodule

FILE: hdl/element_gather_scatter_add_top.sv
// Finite-element gather and scatter-add engine with an offset table and a global vector of
// Q16.16 words, both held in single-port-read synchronous memories. One request is handled at
// a time: an offset load or a global write gives no response, a global read goes through the
// read state, and a sweep step through the offset and global states, as the offset table read
// and the dependent global vector read (and write-back in scatter mode) follow one another.
// A finished response waits in the output register while the next request is taken. Both
// memory depths must be powers of two; entries hold no defined value until written.
module element_gather_scatter_add_top import egsa_pkg::*; #(
   parameter int OFFSET_DEPTH   = OFFSET_DEPTH_DEFAULT,
   parameter int GLOBAL_DEPTH   = GLOBAL_DEPTH_DEFAULT,
   parameter int MAX_NODES      = MAX_NODES_DEFAULT,
   parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int OAW = $clog2(OFFSET_DEPTH);
   localparam int GDW = $clog2(GLOBAL_DEPTH);
   localparam int CCW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int KSW = CCW + 12;
   localparam int GAW = KSW + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_OFFSET, ST_GLOBAL} state_type;

   state_type state_ff;

   logic        sweep_mode_ff;
   logic [12:0] element_count_ff;
   logic [6:0]  nodes_ff;
   logic [3:0]  comps_ff;
   logic [11:0] stride_ff;
   logic [12:0] global_size_ff;

   logic [12:0] elems;
   logic [6:0]  nodes;
   logic [3:0]  comps;
   logic [12:0] gsize;

   logic [11:0] offset_mem [OFFSET_DEPTH];
   logic [31:0] global_mem [GLOBAL_DEPTH];
   logic [11:0] off_rdata_ff;
   logic [31:0] glob_rdata_ff;

   logic           off_we, off_re, glob_we, glob_re;
   logic [OAW-1:0] off_waddr;
   logic [GDW-1:0] glob_waddr, glob_raddr;
   logic [31:0]    glob_wdata;

   logic [OAW-1:0] table_index;
   logic [KSW-1:0] stride_offset;
   logic [14:0]    pos_part;
   logic [11:0]    elem_pos;
   logic           sweep_last;

   logic               req_fire, out_free, addr_ok, step_go, rsp_load;
   logic [GAW-1:0]     ga, ga_ff;
   logic               ga_ok, ok_ff;
   logic [14:0]        position, pos_ff;
   logic signed [31:0] value_ff;
   logic signed [32:0] sum;
   logic               sum_ovf;
   logic [31:0]        sat_sum;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   always_comb begin
      elems = element_count_ff;
      if (element_count_ff == 13'd0) begin
         elems = 13'd1;
      end else if (int'(element_count_ff) > ELEMENT_LIMIT) begin
         elems = 13'(ELEMENT_LIMIT);
      end
      nodes = nodes_ff;
      if (nodes_ff == 7'd0) begin
         nodes = 7'd1;
      end else if (int'(nodes_ff) > MAX_NODES) begin
         nodes = 7'(MAX_NODES);
      end
      comps = comps_ff;
      if (comps_ff == 4'd0) begin
         comps = 4'd1;
      end else if (int'(comps_ff) > MAX_COMPONENTS) begin
         comps = 4'(MAX_COMPONENTS);
      end
      gsize = global_size_ff;
      if (global_size_ff == 13'd0) begin
         gsize = 13'd1;
      end else if (int'(global_size_ff) > GLOBAL_DEPTH) begin
         gsize = 13'(GLOBAL_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_mode_ff    <= 1'b0;
         element_count_ff <= 13'd1;
         nodes_ff         <= 7'd1;
         comps_ff         <= 4'd1;
         stride_ff        <= 12'd0;
         global_size_ff   <= 13'd4096;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SWEEP_MODE:        sweep_mode_ff    <= csr_write_data[0];
            CSR_ELEMENT_COUNT:     element_count_ff <= csr_write_data;
            CSR_NODES_PER_ELEMENT: nodes_ff         <= csr_write_data[6:0];
            CSR_COMPONENT_COUNT:   comps_ff         <= csr_write_data[3:0];
            CSR_COMPONENT_STRIDE:  stride_ff        <= csr_write_data[11:0];
            CSR_GLOBAL_SIZE:       global_size_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && (state_ff == ST_READ || state_ff == ST_GLOBAL);
   assign addr_ok   = 13'(req_payload.address) < gsize;
   assign step_go   = req_fire && (req_payload.kind == KIND_SWEEP_STEP);

   egsa_sweep #(
      .OFFSET_DEPTH   (OFFSET_DEPTH),
      .MAX_NODES      (MAX_NODES),
      .MAX_COMPONENTS (MAX_COMPONENTS)
   ) u_sweep (
      .clock            (clock),
      .reset            (reset),
      .step             (step_go),
      .elems            (elems),
      .nodes            (nodes),
      .comps            (comps),
      .stride           (stride_ff),
      .table_index      (table_index),
      .stride_offset_ff (stride_offset),
      .pos_part_ff      (pos_part),
      .elem_pos_ff      (elem_pos),
      .last_ff          (sweep_last)
   );

   assign ga       = GAW'(off_rdata_ff) + GAW'(stride_offset);
   assign ga_ok    = ga < GAW'(gsize);
   assign position = 15'(pos_part * 15'(elems)) + 15'(elem_pos);

   always_comb begin
      sum     = {glob_rdata_ff[31], glob_rdata_ff} + {value_ff[31], value_ff};
      sum_ovf = sum[32] != sum[31];
      sat_sum = sum_ovf ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
   end

   always_comb begin
      off_we     = req_fire && (req_payload.kind == KIND_LOAD_OFFSET);
      off_waddr  = OAW'(req_payload.address);
      off_re     = step_go;
      glob_we    = 1'b0;
      glob_waddr = GDW'(req_payload.address);
      glob_wdata = req_payload.value;
      glob_re    = 1'b0;
      glob_raddr = GDW'(req_payload.address);
      unique case (state_ff)
         ST_IDLE: begin
            glob_we = req_fire && (req_payload.kind == KIND_WRITE_WORD) && addr_ok;
            glob_re = req_fire && (req_payload.kind == KIND_READ_WORD) && addr_ok;
         end
         ST_OFFSET: begin
            glob_re    = ga_ok;
            glob_raddr = GDW'(ga);
         end
         ST_GLOBAL: begin
            glob_we    = out_free && ok_ff && sweep_mode_ff;
            glob_waddr = GDW'(ga_ff);
            glob_wdata = sat_sum;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         offset_mem[off_waddr] <= req_payload.node_offset;
      end
      if (off_re) begin
         off_rdata_ff <= offset_mem[table_index];
      end
   end

   always_ff @(posedge clock) begin
      if (glob_we) begin
         global_mem[glob_waddr] <= glob_wdata;
      end
      if (glob_re) begin
         glob_rdata_ff <= global_mem[glob_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_payload.kind)
                     KIND_READ_WORD: begin
                        ga_ff    <= GAW'(req_payload.address);
                        ok_ff    <= addr_ok;
                        state_ff <= ST_READ;
                     end
                     KIND_SWEEP_STEP: begin
                        value_ff <= req_payload.value;
                        state_ff <= ST_OFFSET;
                     end
                     KIND_LOAD_OFFSET, KIND_WRITE_WORD: ;
                  endcase
               end
            end
            ST_READ: begin
               if (out_free) begin
                  rsp_payload_ff.data             <= ok_ff ? glob_rdata_ff : 32'd0;
                  rsp_payload_ff.element_position <= 15'd0;
                  rsp_payload_ff.global_address   <= ga_ff[11:0];
                  rsp_payload_ff.sweep_last       <= 1'b0;
                  rsp_payload_ff.fault            <= !ok_ff;
                  state_ff                        <= ST_IDLE;
               end
            end
            ST_OFFSET: begin
               ga_ff    <= ga;
               ok_ff    <= ga_ok;
               pos_ff   <= position;
               state_ff <= ST_GLOBAL;
            end
            ST_GLOBAL: begin
               if (out_free) begin
                  rsp_payload_ff.element_position <= pos_ff;
                  rsp_payload_ff.global_address   <= ga_ff[11:0];
                  rsp_payload_ff.sweep_last       <= sweep_last;
                  if (!ok_ff) begin
                     rsp_payload_ff.data  <= 32'd0;
                     rsp_payload_ff.fault <= 1'b1;
                  end else if (sweep_mode_ff) begin
                     rsp_payload_ff.data  <= sat_sum;
                     rsp_payload_ff.fault <= sum_ovf;
                  end else begin
                     rsp_payload_ff.data  <= glob_rdata_ff;
                     rsp_payload_ff.fault <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_step_sequence: assert property (@(posedge clock) disable iff (reset)
      step_go |=> (state_ff == ST_OFFSET) ##1 (state_ff == ST_GLOBAL))
      else $error("Sweep step did not pass through the offset and global reads.");

   a_global_write_slot: assert property (@(posedge clock) disable iff (reset)
      glob_we |-> (state_ff == ST_IDLE) || (state_ff == ST_GLOBAL && ok_ff && sweep_mode_ff))
      else $error("Global memory written outside a plain write or a scatter write-back.");

   a_read_response: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && out_free) |=>
         rsp_valid_ff && rsp_payload_ff.element_position == 15'd0 && !rsp_payload_ff.sweep_last)
      else $error("Read response carries sweep fields.");

   a_fault_no_data: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GLOBAL && out_free && !ok_ff) |=>
         rsp_payload_ff.fault && rsp_payload_ff.data == 32'd0)
      else $error("Out-of-range step did not return zero data with a fault.");

   a_response_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ || state_ff == ST_GLOBAL))
      else $error("Response raised outside the read or global state.");

endmodule

FILE: sim/tb_element_gather_scatter_add_top.sv
`timescale 1ns / 1ps

module tb_element_gather_scatter_add_top;
   import egsa_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [12:0] MODE_GATHER = 13'd0;
   localparam logic [12:0] MODE_SCATTER = 13'd1;

   // Tracks the offset table, the global vector and the sweep counters, and keeps the
   // responses still owed by the block in request order.
   class restriction_tracker;
      logic [11:0] offsets [OFFSET_DEPTH_DEFAULT];
      bit offset_loaded [OFFSET_DEPTH_DEFAULT];
      logic [31:0] words [GLOBAL_DEPTH_DEFAULT];
      bit word_written [GLOBAL_DEPTH_DEFAULT];
      bit scatter_mode = 1'b0;
      int unsigned element_reg = 1, node_reg = 1, component_reg = 1, stride_reg = 0;
      int unsigned size_reg = 4096;
      int unsigned element_ctr = 0, component_ctr = 0, node_ctr = 0;
      rsp_payload_type awaited_responses [$];
      int mismatches = 0;

      function int unsigned bounded(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function int unsigned global_limit();
         return bounded(size_reg, GLOBAL_DEPTH_DEFAULT);
      endfunction

      function int unsigned table_index();
         return (element_ctr * bounded(node_reg, MAX_NODES_DEFAULT) + node_ctr)
                % OFFSET_DEPTH_DEFAULT;
      endfunction

      function int unsigned step_target();
         return offsets[table_index()] + component_ctr * stride_reg;
      endfunction

      function void set_register(csr_index_type idx, logic [12:0] d);
         case (idx)
            CSR_SWEEP_MODE: scatter_mode = d[0];
            CSR_ELEMENT_COUNT: element_reg = d;
            CSR_NODES_PER_ELEMENT: node_reg = d[6:0];
            CSR_COMPONENT_COUNT: component_reg = d[3:0];
            CSR_COMPONENT_STRIDE: stride_reg = d[11:0];
            CSR_GLOBAL_SIZE: size_reg = d;
            default: ;
         endcase
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type want;
         int unsigned elems, nodes, comps, gsize, target, position;
         longint sum;
         elems = bounded(element_reg, ELEMENT_LIMIT);
         nodes = bounded(node_reg, MAX_NODES_DEFAULT);
         comps = bounded(component_reg, MAX_COMPONENTS_DEFAULT);
         gsize = global_limit();
         want = '0;
         case (r.kind)
            KIND_LOAD_OFFSET: begin
               offsets[r.address] = r.node_offset;
               offset_loaded[r.address] = 1'b1;
               return;
            end
            KIND_WRITE_WORD: begin
               if (r.address < gsize) begin
                  words[r.address] = r.value;
                  word_written[r.address] = 1'b1;
               end
               return;
            end
            KIND_READ_WORD: begin
               want.global_address = r.address;
               if (r.address < gsize) want.data = words[r.address];
               else want.fault = 1'b1;
            end
            KIND_SWEEP_STEP: begin
               target = step_target();
               position = (component_ctr * nodes + node_ctr) * elems + element_ctr;
               want.element_position = position[14:0];
               want.global_address = target[11:0];
               if (target >= gsize) begin
                  want.fault = 1'b1;
               end else if (!scatter_mode) begin
                  want.data = words[target];
               end else begin
                  sum = longint'($signed(words[target])) + longint'(r.value);
                  if (sum > 64'sh7fff_ffff) begin
                     sum = 64'sh7fff_ffff;
                     want.fault = 1'b1;
                  end
                  if (sum < -64'sh8000_0000) begin
                     sum = -64'sh8000_0000;
                     want.fault = 1'b1;
                  end
                  want.data = sum[31:0];
                  words[target] = sum[31:0];
               end
               node_ctr++;
               if (node_ctr >= nodes) begin
                  node_ctr = 0;
                  component_ctr++;
                  if (component_ctr >= comps) begin
                     component_ctr = 0;
                     element_ctr++;
                     if (element_ctr >= elems) begin
                        element_ctr = 0;
                        want.sweep_last = 1'b1;
                     end
                  end
               end
            end
         endcase
         awaited_responses.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_responses.size() == 0) begin
            $display("%0t: response expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = awaited_responses.pop_front();
         compare_field("data", want.data, got.data);
         compare_field("element_position", want.element_position, got.element_position);
         compare_field("global_address", want.global_address, got.global_address);
         compare_field("sweep_last", want.sweep_last, got.sweep_last);
         compare_field("fault", want.fault, got.fault);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SWEEP_MODE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles = 0;
   restriction_tracker book = new();

   element_gather_scatter_add_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) book.check_response(rsp_payload);
         rsp_ready <= !($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [11:0] random_address();
      if ($urandom_range(4) != 0) return 12'($urandom_range(book.global_limit() - 1));
      return 12'($urandom);
   endfunction

   task automatic send_request(input kind_type kind, input logic [11:0] address,
                               input logic [11:0] node_offset, input logic [31:0] value);
      req_payload_type item;
      item.kind = kind;
      item.address = address;
      item.node_offset = node_offset;
      item.value = value;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      book.note_request(item);
   endtask

   // A step only goes out once its offset entry and, if in range, its global word hold data.
   task automatic sweep_step(input logic [31:0] addend);
      int unsigned slot, target;
      slot = book.table_index();
      if (!book.offset_loaded[slot])
         send_request(KIND_LOAD_OFFSET, 12'(slot), random_address(), $urandom);
      target = book.step_target();
      if (target < book.global_limit() && !book.word_written[target])
         send_request(KIND_WRITE_WORD, 12'(target), 12'($urandom), random_word());
      send_request(KIND_SWEEP_STEP, 12'($urandom), 12'($urandom), addend);
   endtask

   task automatic read_word(input logic [11:0] address);
      if (address < book.global_limit() && !book.word_written[address])
         send_request(KIND_WRITE_WORD, address, 12'($urandom), random_word());
      send_request(KIND_READ_WORD, address, 12'($urandom), $urandom);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_register(input csr_index_type idx, input logic [12:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      book.set_register(idx, data);
   endtask

   task automatic configure(input logic [12:0] mode, input logic [12:0] elems,
                            input logic [12:0] nodes, input logic [12:0] comps,
                            input logic [12:0] stride, input logic [12:0] gsize);
      put_register(CSR_SWEEP_MODE, mode);
      put_register(CSR_ELEMENT_COUNT, elems);
      put_register(CSR_NODES_PER_ELEMENT, nodes);
      put_register(CSR_COMPONENT_COUNT, comps);
      put_register(CSR_COMPONENT_STRIDE, stride);
      put_register(CSR_GLOBAL_SIZE, gsize);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [12:0] mode, input logic [12:0] elems,
                            input logic [12:0] nodes, input logic [12:0] comps,
                            input logic [12:0] stride, input logic [12:0] gsize,
                            input int count, input int step_pct, input int pacing);
      int pick;
      drain();
      configure(mode, elems, nodes, comps, stride, gsize);
      case (pacing % 4)
         0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         1: begin send_idle_pct = 58; rsp_stall_pct = 0; end
         2: begin send_idle_pct = 0; rsp_stall_pct = 58; end
         default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
      endcase
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < step_pct) begin
            sweep_step(random_word());
         end else begin
            case (pick % 3)
               0: send_request(KIND_LOAD_OFFSET,
                               $urandom_range(1) ? 12'(book.table_index() + $urandom_range(7))
                                                 : 12'($urandom),
                               random_address(), $urandom);
               1: send_request(KIND_WRITE_WORD, random_address(), 12'($urandom),
                               random_word());
               default: read_word(random_address());
            endcase
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: single-entry gather sweeps over the full global vector.
      send_request(KIND_WRITE_WORD, 12'd0, 12'd0, 32'h7fff_ffff);
      send_request(KIND_WRITE_WORD, 12'hfff, 12'hfff, 32'h8000_0000);
      read_word(12'd0);
      read_word(12'hfff);
      send_request(KIND_LOAD_OFFSET, 12'd0, 12'd0, 32'd0);
      sweep_step(32'd0);
      send_request(KIND_LOAD_OFFSET, 12'd0, 12'hfff, 32'hffff_ffff);
      sweep_step(32'd0);
      send_request(KIND_LOAD_OFFSET, 12'hfff, 12'hfff, 32'd0);

      // Oversized registers saturate; scatter sums clip at both ends and the element
      // position wraps once the node counter reaches eight.
      drain();
      configure(MODE_SCATTER, 13'h1fff, 13'd127, 13'd15, 13'hfff, 13'h1fff);
      send_request(KIND_LOAD_OFFSET, 12'd0, 12'd0, 32'd0);
      sweep_step(32'd1);
      send_request(KIND_LOAD_OFFSET, 12'd1, 12'hfff, 32'd0);
      sweep_step(32'h8000_0000);
      repeat (8) sweep_step(random_word());

      // Zero registers act as one, so the node counter now sits beyond its limit.
      drain();
      configure(MODE_GATHER, 13'd0, 13'd0, 13'd0, 13'hfff, 13'd0);
      sweep_step(32'd0);
      send_request(KIND_WRITE_WORD, 12'd5, 12'd0, $urandom);
      read_word(12'd5);
      read_word(12'hfff);
      sweep_step(32'd0);

      run_phase(MODE_GATHER, 13'd3, 13'd2, 13'd2, 13'd5, 13'd64, 200, 55, 0);
      run_phase(MODE_SCATTER, 13'd4, 13'd3, 13'd1, 13'd0, 13'd4096, 200, 55, 1);
      run_phase(MODE_SCATTER, 13'd2, 13'd1, 13'd3, 13'd4095, 13'd4096, 200, 55, 2);
      // Many elements with one node each, then 64 nodes, so the table index wraps.
      run_phase(MODE_GATHER, 13'd4096, 13'd1, 13'd1, 13'd1, 13'd100, 150, 90, 3);
      run_phase(MODE_SCATTER, 13'd4096, 13'd64, 13'd8, 13'd17, 13'd4096, 200, 70, 0);

      for (int p = 0; p < 5; p++) begin
         logic [12:0] elems, nodes, comps, stride, gsize;
         case ($urandom_range(9))
            0: elems = 13'd0;
            1: elems = 13'($urandom);
            default: elems = 13'($urandom_range(1, 8));
         endcase
         case ($urandom_range(9))
            0: nodes = 13'd0;
            1: nodes = 13'($urandom_range(127));
            default: nodes = 13'($urandom_range(1, 5));
         endcase
         case ($urandom_range(9))
            0: comps = 13'd0;
            1: comps = 13'($urandom_range(15));
            default: comps = 13'($urandom_range(1, 3));
         endcase
         stride = $urandom_range(1) ? 13'($urandom_range(16)) : 13'($urandom_range(4095));
         case ($urandom_range(7))
            0: gsize = 13'd0;
            1: gsize = 13'($urandom);
            2: gsize = 13'd1;
            default: gsize = 13'($urandom_range(16, 4096));
         endcase
         run_phase($urandom_range(1) ? MODE_SCATTER : MODE_GATHER, elems, nodes, comps,
                   stride, gsize, 200, 55, p + 1);
      end

      drain();
      if (book.mismatches == 0 && book.awaited_responses.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
